>>> hw/rtl/cap_pkg.sv
`timescale 1ns / 1ps

package cap_pkg;

    // Shared serial multiply/divide unit sizing
    localparam int unsigned ARITH_W   = 70;  // product / dividend width
    localparam int unsigned DEN_W     = 26;  // divisor / multiplier width
    localparam int unsigned MUL_STEPS = 20;  // multiplier bits, one per cycle
    localparam int unsigned DIV_STEPS = ARITH_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // One million: microseconds per second
    localparam logic [DEN_W-1:0] MICRO = DEN_W'(1000000);

    // ceil(2^61 / 15625): floor(y / 15625) = (y * KI_RECIP) >> 61, exact for y < 2^47
    localparam logic [47:0] KI_RECIP = 48'd147573952589677;

    localparam logic [7:0] TILT_RESET = 8'd30;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } t_arith_op;

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_ROLL_ANGLE  = 3'd0,
        REG_PITCH_ANGLE = 3'd1,
        REG_YAW_ANGLE   = 3'd2,
        REG_ROLL_RATE   = 3'd3,
        REG_PITCH_RATE  = 3'd4,
        REG_YAW_RATE    = 3'd5,
        REG_MAX_TILT    = 3'd6
    } t_reg_idx;

    // Packed gains: kp in 15:0, ki in 31:16, kd in 47:32
    typedef struct packed {
        logic [15:0] kd;
        logic [15:0] ki;
        logic [15:0] kp;
    } t_gains;

    typedef struct packed {
        logic               start;
        t_arith_op          op;
        logic [ARITH_W-1:0] a;
        logic [DEN_W-1:0]   b;
    } t_arith_req;

    typedef struct packed {
        logic               done;
        logic [ARITH_W-1:0] result;
    } t_arith_rsp;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] cmd;
    } t_lane_sts;

endpackage

>>> hw/rtl/cap_if.sv
`timescale 1ns / 1ps

// Input channel: one sensor/stick sample per transfer
interface cap_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] stick_roll;
    logic signed [15:0] stick_pitch;
    logic signed [15:0] stick_yaw;
    logic signed [15:0] meas_angle_roll;
    logic signed [15:0] meas_angle_pitch;
    logic signed [15:0] meas_angle_yaw;
    logic signed [15:0] gyro_rate_x;
    logic signed [15:0] gyro_rate_y;
    logic signed [15:0] gyro_rate_z;
    logic [15:0]        step_time_us;

    modport source (
        output valid, stick_roll, stick_pitch, stick_yaw,
        output meas_angle_roll, meas_angle_pitch, meas_angle_yaw,
        output gyro_rate_x, gyro_rate_y, gyro_rate_z, step_time_us,
        input  ready
    );
    modport sink (
        input  valid, stick_roll, stick_pitch, stick_yaw,
        input  meas_angle_roll, meas_angle_pitch, meas_angle_yaw,
        input  gyro_rate_x, gyro_rate_y, gyro_rate_z, step_time_us,
        output ready
    );
endinterface

// Output channel: three drive commands per transfer
interface cap_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_command;
    logic signed [31:0] pitch_command;
    logic signed [31:0] yaw_command;

    modport source (
        output valid, roll_command, pitch_command, yaw_command,
        input  ready
    );
    modport sink (
        input  valid, roll_command, pitch_command, yaw_command,
        output ready
    );
endinterface

>>> hw/rtl/cap_arith.sv
`timescale 1ns / 1ps

// Bit-serial unsigned multiply (shift-add) and restoring divide.
module cap_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cap_pkg::t_arith_req i_req,
    output cap_pkg::t_arith_rsp o_rsp
);

    localparam logic [cap_pkg::CNT_W-1:0] MUL_LAST = cap_pkg::CNT_W'(cap_pkg::MUL_STEPS - 1);
    localparam logic [cap_pkg::CNT_W-1:0] DIV_LAST = cap_pkg::CNT_W'(cap_pkg::DIV_STEPS - 1);

    logic                           r_busy;
    logic                           r_done;
    cap_pkg::t_arith_op             r_op;
    logic [cap_pkg::CNT_W-1:0]      r_cnt;
    logic [cap_pkg::ARITH_W-1:0]    r_a;    // multiplicand, or dividend/quotient
    logic [cap_pkg::DEN_W-1:0]      r_b;    // multiplier, or divisor
    logic [cap_pkg::ARITH_W-1:0]    r_acc;
    logic [cap_pkg::DEN_W-1:0]      r_rem;

    logic [cap_pkg::DEN_W:0]        w_rem_sh;
    logic [cap_pkg::DEN_W:0]        w_rem_sub;
    logic                           w_fits;
    logic                           w_last;

    // One restoring step
    assign w_rem_sh  = {r_rem, r_a[cap_pkg::ARITH_W-1]};
    assign w_fits    = (w_rem_sh >= {1'b0, r_b});
    assign w_rem_sub = w_rem_sh - {1'b0, r_b};
    assign w_last    = (r_op == cap_pkg::OP_MUL) ? (r_cnt == MUL_LAST) : (r_cnt == DIV_LAST);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            case (r_op)
                cap_pkg::OP_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= {r_a[cap_pkg::ARITH_W-2:0], 1'b0};
                    r_b <= {1'b0, r_b[cap_pkg::DEN_W-1:1]};
                end
                cap_pkg::OP_DIV: begin
                    r_rem <= w_fits ? w_rem_sub[cap_pkg::DEN_W-1:0]
                                    : w_rem_sh[cap_pkg::DEN_W-1:0];
                    r_a   <= {r_a[cap_pkg::ARITH_W-2:0], w_fits};
                end
                default: begin
                    r_a <= r_a;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == cap_pkg::OP_MUL) ? r_acc : r_a;

endmodule

>>> hw/rtl/cap_lane.sv
`timescale 1ns / 1ps

// One axis: angle PID then rate PID, sequenced over a serial mul/div unit.
module cap_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_ack,
    input  logic signed [15:0] i_stick,
    input  logic signed [15:0] i_angle,
    input  logic signed [15:0] i_gyro,
    input  logic [15:0]        i_dt,
    input  logic [7:0]         i_tilt,
    input  cap_pkg::t_gains    i_gains_angle,
    input  cap_pkg::t_gains    i_gains_rate,
    output cap_pkg::t_lane_sts o_sts
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_ERR  = 11'b000_0000_0010,
        S_PRE  = 11'b000_0000_0100,
        S_INT  = 11'b000_0000_1000,
        S_IREQ = 11'b000_0001_0000,
        S_IMUL = 11'b000_0010_0000,
        S_IRCP = 11'b000_0100_0000,
        S_DMUL = 11'b000_1000_0000,
        S_DDIV = 11'b001_0000_0000,
        S_SUM  = 11'b010_0000_0000,
        S_NEXT = 11'b100_0000_0000
    } t_lane_state;

    localparam logic signed [47:0] I48_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] I48_MIN = {1'b1, 47'd0};
    localparam logic signed [31:0] I32_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] I32_MIN = {1'b1, 31'd0};
    localparam logic [47:0]        RECIP   = cap_pkg::KI_RECIP;

    t_lane_state         r_state;
    logic                r_done_st;
    logic                r_sel;         // 0: angle PID, 1: rate PID
    logic signed [31:0]  r_e;
    logic signed [47:0]  r_integ [2];
    logic signed [31:0]  r_last [2];
    logic signed [48:0]  r_edt;
    logic signed [38:0]  r_pterm;
    logic signed [49:0]  r_q;
    logic                r_qneg;
    logic [48:0]         r_qmag;
    logic                r_ineg;
    logic [35:0]         r_iterm;
    logic [60:0]         r_dterm;
    logic signed [31:0]  r_out;
    logic [31:0]         r_cmd;
    logic [46:0]         r_ry;          // ki*|I| / 65536
    logic [94:0]         r_racc;
    logic [1:0]          r_rcnt;
    cap_pkg::t_arith_req r_req;
    cap_pkg::t_arith_rsp w_rsp;

    cap_pkg::t_gains     w_g;
    logic signed [24:0]  w_tilt_prod;
    logic signed [24:0]  w_tilt_adj;
    logic signed [17:0]  w_aerr;
    logic signed [47:0]  w_integ;
    logic signed [31:0]  w_last;
    logic signed [48:0]  w_edt;
    logic signed [48:0]  w_kpe;
    logic signed [48:0]  w_kpe_adj;
    logic signed [32:0]  w_de;
    logic signed [49:0]  w_q;
    logic signed [49:0]  w_isum;
    logic signed [47:0]  w_isat;
    logic [47:0]         w_imag;
    logic [49:0]         w_qneg_v;
    logic [48:0]         w_qmag;
    logic [15:0]         w_rchunk;
    logic [62:0]         w_rprod;
    logic [94:0]         w_racc_nx;
    logic [35:0]         w_iq;
    logic [35:0]         w_iterm;
    logic [60:0]         w_dq;
    logic [60:0]         w_dterm;
    logic signed [63:0]  w_sum;
    logic signed [31:0]  w_osat;
    logic signed [32:0]  w_rerr;
    logic signed [31:0]  w_rsat;

    cap_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    assign w_g     = r_sel ? i_gains_rate : i_gains_angle;
    assign w_integ = r_integ[r_sel];
    assign w_last  = r_last[r_sel];

    // Angle setpoint, truncated toward zero, minus measured angle
    assign w_tilt_prod = i_stick * $signed({1'b0, i_tilt});
    assign w_tilt_adj  = w_tilt_prod + $signed({17'd0, {8{w_tilt_prod[24]}}});
    assign w_aerr      = $signed({w_tilt_adj[24], w_tilt_adj[24:8]})
                       - $signed({{2{i_angle[15]}}, i_angle});

    // Products of the first PID step
    assign w_edt     = r_e * $signed({1'b0, i_dt});
    assign w_kpe     = $signed({1'b0, w_g.kp}) * r_e;
    assign w_kpe_adj = w_kpe + $signed({39'd0, {10{w_kpe[48]}}});
    assign w_de      = $signed({r_e[31], r_e}) - $signed({w_last[31], w_last});
    assign w_q       = $signed({1'b0, w_g.kd}) * w_de;

    // Integral update with 48-bit saturation
    assign w_isum = $signed({{2{w_integ[47]}}, w_integ}) + $signed({r_edt[48], r_edt});
    always_comb begin
        if ((w_isum[49:47] != 3'b000) && (w_isum[49:47] != 3'b111)) begin
            w_isat = w_isum[49] ? I48_MIN : I48_MAX;
        end else begin
            w_isat = w_isum[47:0];
        end
    end

    // Magnitudes for the unsigned serial unit
    assign w_imag   = w_integ[47] ? (~w_integ + 48'd1) : w_integ;
    assign w_qneg_v = ~r_q + 50'd1;
    assign w_qmag   = r_q[49] ? w_qneg_v[48:0] : r_q[48:0];

    // Divide by 15625 as a reciprocal multiply, 16 multiplier bits per cycle, top first
    always_comb begin
        case (r_rcnt)
            2'd0:    w_rchunk = RECIP[47:32];
            2'd1:    w_rchunk = RECIP[31:16];
            default: w_rchunk = RECIP[15:0];
        endcase
    end
    assign w_rprod   = r_ry * w_rchunk;
    assign w_racc_nx = {r_racc[78:0], 16'd0} + {32'd0, w_rprod};

    // Signed terms from quotients
    assign w_iq    = {2'b0, w_racc_nx[94:61]};
    assign w_iterm = r_ineg ? (~w_iq + 36'd1) : w_iq;
    assign w_dq    = {1'b0, w_rsp.result[59:0]};
    assign w_dterm = r_qneg ? (~w_dq + 61'd1) : w_dq;

    // Sum of terms, 32-bit saturation
    assign w_sum = $signed({{25{r_pterm[38]}}, r_pterm})
                 + $signed({{28{r_iterm[35]}}, r_iterm})
                 + $signed({{3{r_dterm[60]}}, r_dterm});
    always_comb begin
        if ((w_sum[63:31] != '0) && (w_sum[63:31] != '1)) begin
            w_osat = w_sum[63] ? I32_MIN : I32_MAX;
        end else begin
            w_osat = w_sum[31:0];
        end
    end

    // Rate error, 32-bit saturation
    assign w_rerr = $signed({r_out[31], r_out}) - $signed({{17{i_gyro[15]}}, i_gyro});
    assign w_rsat = (w_rerr[32] != w_rerr[31]) ? (w_rerr[32] ? I32_MIN : I32_MAX)
                                               : w_rerr[31:0];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_st   <= 1'b0;
            r_sel       <= 1'b0;
            r_req.start <= 1'b0;
            r_integ[0]  <= '0;
            r_integ[1]  <= '0;
            r_last[0]   <= '0;
            r_last[1]   <= '0;
        end else begin
            r_req.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (r_done_st) begin
                        if (i_ack) begin
                            r_done_st <= 1'b0;
                        end
                    end else if (i_start) begin
                        r_sel   <= 1'b0;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_e     <= {{14{w_aerr[17]}}, w_aerr};
                    r_state <= S_PRE;
                end
                S_PRE: begin
                    r_edt         <= w_edt;
                    r_pterm       <= w_kpe_adj[48:10];
                    r_q           <= w_q;
                    r_last[r_sel] <= r_e;
                    r_state       <= S_INT;
                end
                S_INT: begin
                    r_integ[r_sel] <= w_isat;
                    r_qneg         <= r_q[49];
                    r_qmag         <= w_qmag;
                    r_state        <= S_IREQ;
                end
                S_IREQ: begin
                    r_ineg  <= w_integ[47];
                    r_req   <= '{start: 1'b1, op: cap_pkg::OP_MUL,
                                 a: {22'd0, w_imag}, b: {10'd0, w_g.ki}};
                    r_state <= S_IMUL;
                end
                S_IMUL: begin
                    if (w_rsp.done) begin
                        // ki*|I| / 1024e6 = (ki*|I| >> 16) / 15625
                        r_ry    <= w_rsp.result[62:16];
                        r_racc  <= '0;
                        r_rcnt  <= '0;
                        r_state <= S_IRCP;
                    end
                end
                S_IRCP: begin
                    r_racc <= w_racc_nx;
                    r_rcnt <= r_rcnt + 1'b1;
                    if (r_rcnt == 2'd2) begin
                        r_iterm <= w_iterm;
                        if (i_dt == 16'd0) begin
                            r_dterm <= '0;
                            r_state <= S_SUM;
                        end else begin
                            r_req   <= '{start: 1'b1, op: cap_pkg::OP_MUL,
                                         a: {21'd0, r_qmag}, b: cap_pkg::MICRO};
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_DMUL: begin
                    if (w_rsp.done) begin
                        // |kd*de| * 1e6 / (1024*dt)
                        r_req   <= '{start: 1'b1, op: cap_pkg::OP_DIV,
                                     a: w_rsp.result, b: {i_dt, 10'd0}};
                        r_state <= S_DDIV;
                    end
                end
                S_DDIV: begin
                    if (w_rsp.done) begin
                        r_dterm <= w_dterm;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_out   <= w_osat;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (!r_sel) begin
                        r_e     <= w_rsat;
                        r_sel   <= 1'b1;
                        r_state <= S_PRE;
                    end else begin
                        r_cmd     <= r_out;
                        r_done_st <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = r_done_st;
    assign o_sts.cmd  = r_cmd;

endmodule

>>> hw/rtl/cascaded_attitude_pid.sv
`timescale 1ns / 1ps

// Three-axis cascaded attitude PID. Each input transfer carries stick,
// angle and gyro samples for roll, pitch and yaw plus the time step; three
// identical lanes run the angle PID and then the rate PID of their axis in
// parallel, and the merge stage returns the three drive commands as one
// output transfer. Each lane works through its bit-serial multiply/divide
// unit: the integral term takes one serial multiply and a reciprocal
// multiply done in 16-bit chunks, the derivative term a serial multiply and
// a serial divide (skipped when the time step is zero), and the two PIDs of
// an axis run in series. One item is in flight at a time; the next is
// accepted as soon as the commands sit in the output register. Gains and
// max tilt are 64-bit APB registers at byte offset 8*index; write them only
// while idle.
module cascaded_attitude_pid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cap_in_if.sink      i_in,
    cap_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cap_pkg::t_gains    r_gains [6];
    logic [7:0]         r_tilt;
    logic signed [15:0] r_stick [3];
    logic signed [15:0] r_angle [3];
    logic signed [15:0] r_gyro [3];
    logic [15:0]        r_dt;
    logic               r_busy;
    logic               r_start;
    logic               r_out_valid;
    logic [31:0]        r_cmd [3];

    cap_pkg::t_reg_idx  w_idx;
    cap_pkg::t_lane_sts w_sts [3];
    logic [2:0]         w_done;
    logic [2:0]         w_lbusy;
    logic               w_accept;
    logic               w_load;

    // Configuration registers
    assign w_idx  = cap_pkg::t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_gains[k] <= '0;
            end
            r_tilt <= cap_pkg::TILT_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                cap_pkg::REG_ROLL_ANGLE:  r_gains[0] <= pwdata[47:0];
                cap_pkg::REG_PITCH_ANGLE: r_gains[1] <= pwdata[47:0];
                cap_pkg::REG_YAW_ANGLE:   r_gains[2] <= pwdata[47:0];
                cap_pkg::REG_ROLL_RATE:   r_gains[3] <= pwdata[47:0];
                cap_pkg::REG_PITCH_RATE:  r_gains[4] <= pwdata[47:0];
                cap_pkg::REG_YAW_RATE:    r_gains[5] <= pwdata[47:0];
                cap_pkg::REG_MAX_TILT:    r_tilt     <= pwdata[7:0];
                default: begin
                    r_tilt <= r_tilt;
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cap_pkg::REG_ROLL_ANGLE:  prdata = {16'd0, r_gains[0]};
            cap_pkg::REG_PITCH_ANGLE: prdata = {16'd0, r_gains[1]};
            cap_pkg::REG_YAW_ANGLE:   prdata = {16'd0, r_gains[2]};
            cap_pkg::REG_ROLL_RATE:   prdata = {16'd0, r_gains[3]};
            cap_pkg::REG_PITCH_RATE:  prdata = {16'd0, r_gains[4]};
            cap_pkg::REG_YAW_RATE:    prdata = {16'd0, r_gains[5]};
            cap_pkg::REG_MAX_TILT:    prdata = {56'd0, r_tilt};
            default:                  prdata = '0;
        endcase
    end

    // Input transfer: latch the sample and kick the lanes
    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stick[0] <= i_in.stick_roll;
            r_stick[1] <= i_in.stick_pitch;
            r_stick[2] <= i_in.stick_yaw;
            r_angle[0] <= i_in.meas_angle_roll;
            r_angle[1] <= i_in.meas_angle_pitch;
            r_angle[2] <= i_in.meas_angle_yaw;
            r_gyro[0]  <= i_in.gyro_rate_x;
            r_gyro[1]  <= i_in.gyro_rate_y;
            r_gyro[2]  <= i_in.gyro_rate_z;
            r_dt       <= i_in.step_time_us;
        end
    end

    // Axis lanes
    for (genvar g = 0; g < 3; g++) begin : g_lane
        cap_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_start       (r_start),
            .i_ack         (w_load),
            .i_stick       (r_stick[g]),
            .i_angle       (r_angle[g]),
            .i_gyro        (r_gyro[g]),
            .i_dt          (r_dt),
            .i_tilt        (r_tilt),
            .i_gains_angle (r_gains[g]),
            .i_gains_rate  (r_gains[g+3]),
            .o_sts         (w_sts[g])
        );
        assign w_done[g]  = w_sts[g].done;
        assign w_lbusy[g] = w_sts[g].busy;
    end

    // Merge: all three commands go out in one transfer
    assign w_load = r_busy && (&w_done) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd[0] <= w_sts[0].cmd;
            r_cmd[1] <= w_sts[1].cmd;
            r_cmd[2] <= w_sts[2].cmd;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.roll_command  = r_cmd[0];
    assign o_out.pitch_command = r_cmd[1];
    assign o_out.yaw_command   = r_cmd[2];

    // Lanes start together once the sample is latched
    a_lanes_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> (&w_lbusy))
        else $error("lanes did not all start");

    // Lanes run in lock step, so they finish together
    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_done) == 0) || ($countones(w_done) == 3))
        else $error("lanes finished out of step");

    // Leaving busy always leaves a result in the output register
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> o_out.valid)
        else $error("item finished without a result");

endmodule
